// ----- rtl/core/kwmt_pkg.sv -----
// Shared constants and codes for the k-way merge winner tree.
// No dependencies.
`default_nettype none

package kwmt_pkg;

   localparam int NUM_LISTS_DEF  = 8;
   localparam int LIST_DEPTH_DEF = 64;
   localparam int VALUE_BITS_DEF = 32;

   typedef enum logic {
      MODE_PUSH = 1'b0,
      MODE_POP  = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_PUSHED  = 2'd0,
      STATUS_DROPPED = 2'd1,
      STATUS_POPPED  = 2'd2,
      STATUS_EMPTY   = 2'd3
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/core/kwmt_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module kwmt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- rtl/core/kway_merge_winner_tree.sv -----
// K-way merge over per-list LIFO stacks with a registered winner tree.
// Depends on kwmt_pkg and kwmt_ram.
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+-----------
//  request  | req_valid/ready, mode, list_sel, value  | in
//  response | rsp_valid/ready, status, win_value/list | out
//
// One transaction at a time. A push, or a pop that empties its list, then waits in S_SETTLE
// while the winner tree settles; a pop that exposes a stored element first reads the RAM in
// S_POP_RD to refill the popped list's head register. A dropped push or empty pop settles nothing.
// The winner tree settles one register level per cycle.
// Reset empties every list; RAM contents need no clearing.
// A new request waits while the response register is still full.
`default_nettype none

module kway_merge_winner_tree #(
   parameter int NUM_LISTS  = kwmt_pkg::NUM_LISTS_DEF,
   parameter int LIST_DEPTH = kwmt_pkg::LIST_DEPTH_DEF,
   parameter int VALUE_BITS = kwmt_pkg::VALUE_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic                         req_mode,
   input  wire logic [2:0]                   req_list_sel,
   input  wire logic signed [VALUE_BITS-1:0] req_value,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic [1:0]                   rsp_status,
   output      logic signed [VALUE_BITS-1:0] rsp_win_value,
   output      logic [2:0]                   rsp_win_list
);

   localparam int LIST_BITS = $clog2(NUM_LISTS);
   localparam int LEVELS    = LIST_BITS;
   localparam int PAD       = 1 << LEVELS;
   localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
   localparam int TOTAL     = NUM_LISTS * LIST_DEPTH;
   localparam int ADDR_W    = $clog2(TOTAL);
   localparam int SET_W     = $clog2(LEVELS + 1);

   typedef struct packed {
      logic                  vld;
      logic [LIST_BITS-1:0]  idx;
      logic [CNT_W-1:0]      cnt;
      logic [VALUE_BITS-1:0] val;
   } node_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP_RD,
      S_SETTLE
   } state_type;

   state_type             state_ff;
   logic [SET_W-1:0]      settle_ff;
   logic [LIST_BITS-1:0]  pop_list_ff;
   logic [VALUE_BITS-1:0] head_ff  [NUM_LISTS];
   logic [CNT_W-1:0]      count_ff [NUM_LISTS];
   logic                  rsp_valid_ff;
   kwmt_pkg::status_type  rsp_status_ff;
   logic [VALUE_BITS-1:0] rsp_win_value_ff;
   logic [2:0]            rsp_win_list_ff;

   node_type node_ff  [1:PAD-1];
   node_type node_in  [1:PAD-1];
   node_type all_node [1:2*PAD-1];
   node_type root;

   logic                  accept;
   logic                  is_pop;
   logic [LIST_BITS+2:0]  sel_ext;
   logic [LIST_BITS-1:0]  sel_idx;
   logic                  push_ok;
   logic [LIST_BITS+2:0]  win_ext;
   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_addr;
   logic [VALUE_BITS-1:0] ram_rdata;

   // winner tree: leaves from head registers, one register per level
   genvar j;
   generate
      for (j = 1; j < PAD; j++) begin : g_node
         assign all_node[j] = node_ff[j];
      end
      for (j = 0; j < PAD; j++) begin : g_leaf
         if (j < NUM_LISTS) begin : g_used
            assign all_node[PAD+j] = '{vld: (count_ff[j] != '0),
                                       idx: LIST_BITS'(j),
                                       cnt: count_ff[j],
                                       val: head_ff[j]};
         end else begin : g_pad
            assign all_node[PAD+j] = '0;
         end
      end
   endgenerate

   always_comb begin
      for (int n = 1; n < PAD; n++) begin
         // right (higher index) wins ties
         if (all_node[2*n+1].vld && (!all_node[2*n].vld ||
             $signed(all_node[2*n+1].val) >= $signed(all_node[2*n].val))) begin
            node_in[n] = all_node[2*n+1];
         end else begin
            node_in[n] = all_node[2*n];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 1; n < PAD; n++) begin
            node_ff[n].vld <= 1'b0;
         end
      end else begin
         for (int n = 1; n < PAD; n++) begin
            node_ff[n] <= node_in[n];
         end
      end
   end

   assign root = node_ff[1];

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign is_pop    = (req_mode == kwmt_pkg::MODE_POP);
   assign sel_ext   = (LIST_BITS+3)'(req_list_sel);
   assign sel_idx   = sel_ext[LIST_BITS-1:0];
   assign push_ok   = (sel_ext < (LIST_BITS+3)'(NUM_LISTS)) &&
                      (count_ff[sel_idx] != CNT_W'(LIST_DEPTH));
   assign win_ext   = (LIST_BITS+3)'(root.idx);

   assign ram_we = accept && !is_pop && push_ok;

   always_comb begin
      if (!is_pop) begin
         ram_addr = ADDR_W'(sel_idx) * ADDR_W'(LIST_DEPTH) + ADDR_W'(count_ff[sel_idx]);
      end else begin
         ram_addr = ADDR_W'(root.idx) * ADDR_W'(LIST_DEPTH) + ADDR_W'(root.cnt)
                    - ADDR_W'(1) - ADDR_W'(1);
      end
   end

   kwmt_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (TOTAL)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_value),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         settle_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready && !accept) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_win_value_ff <= '0;
                  rsp_win_list_ff  <= '0;
                  if (!is_pop) begin
                     if (push_ok) begin
                        head_ff[sel_idx]  <= req_value;
                        count_ff[sel_idx] <= count_ff[sel_idx] + CNT_W'(1);
                        rsp_status_ff     <= kwmt_pkg::STATUS_PUSHED;
                        settle_ff         <= SET_W'(LEVELS - 1);
                        state_ff          <= S_SETTLE;
                     end else begin
                        rsp_status_ff <= kwmt_pkg::STATUS_DROPPED;
                     end
                  end else if (root.vld) begin
                     rsp_status_ff      <= kwmt_pkg::STATUS_POPPED;
                     rsp_win_value_ff   <= root.val;
                     rsp_win_list_ff    <= win_ext[2:0];
                     count_ff[root.idx] <= root.cnt - CNT_W'(1);
                     pop_list_ff        <= root.idx;
                     settle_ff          <= SET_W'(LEVELS - 1);
                     if (root.cnt > CNT_W'(1)) begin
                        state_ff <= S_POP_RD;
                     end else begin
                        state_ff <= S_SETTLE;
                     end
                  end else begin
                     rsp_status_ff <= kwmt_pkg::STATUS_EMPTY;
                  end
               end
            end
            S_POP_RD: begin
               head_ff[pop_list_ff] <= ram_rdata;
               state_ff             <= S_SETTLE;
            end
            S_SETTLE: begin
               if (settle_ff == '0) begin
                  state_ff <= S_IDLE;
               end else begin
                  settle_ff <= settle_ff - SET_W'(1);
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_win_value = rsp_win_value_ff;
   assign rsp_win_list  = rsp_win_list_ff;

endmodule

`default_nettype wire
